FILE: src/ils_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ils_pkg: shared types and codes for the indexed list store
// Operation codes, status codes, datapath command kinds and the command and
// status bundles that run between the controller and the datapath.
// ----------------------------------------------------------------------------
package ils_pkg;

  // Default parameter values
  localparam int CAPACITY_DEF   = 32;
  localparam int DATA_WIDTH_DEF = 32;

  // Fixed port widths
  localparam int OP_W  = 3;
  localparam int POS_W = 6;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;
  localparam int LEN_W = 6;

  // Request operations
  localparam logic [OP_W-1:0] OP_APPEND    = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT    = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE    = 3'd2;
  localparam logic [OP_W-1:0] OP_READ      = 3'd3;
  localparam logic [OP_W-1:0] OP_OVERWRITE = 3'd4;

  // Result status
  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  // Datapath actions
  localparam logic [2:0] KIND_NONE   = 3'd0;
  localparam logic [2:0] KIND_APPEND = 3'd1;
  localparam logic [2:0] KIND_INSERT = 3'd2;
  localparam logic [2:0] KIND_REMOVE = 3'd3;
  localparam logic [2:0] KIND_READ   = 3'd4;
  localparam logic [2:0] KIND_WRITE  = 3'd5;

  // Controller to datapath
  typedef struct packed {
    logic            capture;  // latch request operands
    logic            exec;     // apply action and register result
    logic [2:0]      kind;
    logic [ST_W-1:0] status;
  } ils_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_range;  // position below current count
    logic full;      // count at capacity
  } ils_sts_t;

endpackage

FILE: src/ils_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ils_ctrl: request sequencer for the indexed list store
// Accepts a request, decodes it against the datapath status in the
// following cycle and issues one action plus the result status.
// ----------------------------------------------------------------------------
module ils_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [ils_pkg::OP_W-1:0] in_op,
  input  ils_pkg::ils_sts_t      sts,
  output ils_pkg::ils_cmd_t      cmd,
  output logic                   busy,
  output logic                   out_valid
);
  import ils_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic            state_r, state_nxt;
  logic [OP_W-1:0] op_r;
  logic            out_valid_r;
  logic [2:0]      kind;
  logic [ST_W-1:0] status;

  assign busy      = (state_r == S_EXEC);
  assign out_valid = out_valid_r;

  // Decode the held operation against the list status
  always_comb begin
    kind   = KIND_NONE;
    status = ST_DONE;
    case (op_r)
      OP_APPEND: begin
        if (sts.full) status = ST_FULL;
        else kind = KIND_APPEND;
      end
      OP_INSERT: begin
        if (!sts.in_range) status = ST_RANGE;
        else if (sts.full) status = ST_FULL;
        else kind = KIND_INSERT;
      end
      OP_REMOVE: begin
        if (!sts.in_range) status = ST_RANGE;
        else kind = KIND_REMOVE;
      end
      OP_READ: begin
        if (!sts.in_range) status = ST_RANGE;
        else kind = KIND_READ;
      end
      OP_OVERWRITE: begin
        if (!sts.in_range) status = ST_RANGE;
        else kind = KIND_WRITE;
      end
      default: status = ST_RANGE;
    endcase
  end

  // Advance the state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (start) state_nxt = S_EXEC;
      S_EXEC:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.capture = (state_r == S_IDLE) && start;
    cmd.exec    = (state_r == S_EXEC);
    cmd.kind    = kind;
    cmd.status  = status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_EXEC);
    end
  end

  // Hold the operation of the accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.capture) op_r <= in_op;
  end

`ifndef SYNTHESIS
  a_exec_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EXEC |=> state_r == S_IDLE)
    else $error("execute state held more than one cycle");
  a_accept_to_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transaction did not enter execute");
  a_strobe_follows_exec: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_valid)
    else $error("result strobe missing after execute");
  a_no_strobe_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe overlaps execute");
`endif

endmodule

FILE: src/ils_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ils_dpath: slot row and result registers for the indexed list store
// A row of word cells, each wired to its neighbors so that insert and
// remove shift every affected cell in parallel; plus the fill count.
// ----------------------------------------------------------------------------
module ils_dpath #(
  parameter int CAPACITY   = ils_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = ils_pkg::DATA_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [ils_pkg::POS_W-1:0] in_position,
  input  logic [ils_pkg::VAL_W-1:0] in_item_value,
  input  ils_pkg::ils_cmd_t         cmd,
  output ils_pkg::ils_sts_t         sts,
  output logic [ils_pkg::VAL_W-1:0] out_read_value,
  output logic [ils_pkg::ST_W-1:0]  out_status,
  output logic [ils_pkg::LEN_W-1:0] out_length
);
  import ils_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  logic [DATA_WIDTH-1:0] slot_r   [CAPACITY];
  logic [DATA_WIDTH-1:0] slot_nxt [CAPACITY];
  logic [CW-1:0]         count_r, count_nxt;
  logic [POS_W-1:0]      pos_r;
  logic [DATA_WIDTH-1:0] word_r;
  logic [PW-1:0]         pos_ext;
  logic [PW-1:0]         count_ext;
  logic [PW-1:0]         count_nxt_ext;
  logic [DATA_WIDTH-1:0] rd_word;
  logic [VAL_W-1:0]      rd_out;
  logic [DATA_WIDTH-1:0] in_word;
  logic [VAL_W-1:0]      read_value_r;
  logic [ST_W-1:0]       status_r;
  logic [LEN_W-1:0]      length_r;

  assign pos_ext       = PW'(pos_r);
  assign count_ext     = PW'(count_r);
  assign count_nxt_ext = PW'(count_nxt);

  // Fit the request word to the storage width, and the stored word to the port
  generate
    if (DATA_WIDTH <= VAL_W) begin : g_narrow
      assign in_word = in_item_value[DATA_WIDTH-1:0];
      assign rd_out  = VAL_W'(rd_word);
    end else begin : g_wide
      assign in_word = DATA_WIDTH'(in_item_value);
      assign rd_out  = rd_word[VAL_W-1:0];
    end
  endgenerate

  // Status for the controller
  assign sts.in_range = (pos_ext < count_ext);
  assign sts.full     = (count_r == CW'(CAPACITY));

  // Select the addressed cell
  assign rd_word = slot_r[pos_ext[IW-1:0]];

  // Next value of each cell from itself, its neighbors and the request word
  generate
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [DATA_WIDTH-1:0] lower_w;
      logic [DATA_WIDTH-1:0] upper_w;
      if (g == 0) begin : g_lo
        assign lower_w = slot_r[g];
      end else begin : g_mid_lo
        assign lower_w = slot_r[g-1];
      end
      if (g == CAPACITY - 1) begin : g_hi
        assign upper_w = '0;
      end else begin : g_mid_hi
        assign upper_w = slot_r[g+1];
      end

      always_comb begin
        slot_nxt[g] = slot_r[g];
        if (cmd.exec) begin
          case (cmd.kind)
            KIND_APPEND: if (count_ext == PW'(g)) slot_nxt[g] = word_r;
            KIND_INSERT: begin
              if (PW'(g) == pos_ext) slot_nxt[g] = word_r;
              else if (PW'(g) > pos_ext) slot_nxt[g] = lower_w;
            end
            KIND_REMOVE: if (PW'(g) >= pos_ext) slot_nxt[g] = upper_w;
            KIND_WRITE:  if (PW'(g) == pos_ext) slot_nxt[g] = word_r;
            default:     slot_nxt[g] = slot_r[g];
          endcase
        end
      end

      // Clear the cell on reset so slots above the count hold zero
      always_ff @(posedge clk) begin
        if (!rst_n) slot_r[g] <= '0;
        else slot_r[g] <= slot_nxt[g];
      end
    end
  endgenerate

  // Step the fill count
  always_comb begin
    count_nxt = count_r;
    if (cmd.exec) begin
      case (cmd.kind)
        KIND_APPEND, KIND_INSERT: count_nxt = count_r + CW'(1);
        KIND_REMOVE:              count_nxt = count_r - CW'(1);
        default:                  count_nxt = count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= '0;
    else count_r <= count_nxt;
  end

  // Hold the operands of the accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pos_r  <= in_position;
      word_r <= in_word;
    end
  end

  // Register the result
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      read_value_r <= (cmd.kind == KIND_READ) ? rd_out : '0;
      status_r     <= cmd.status;
      length_r     <= count_nxt_ext[LEN_W-1:0];
    end
  end

  assign out_read_value = read_value_r;
  assign out_status     = status_r;
  assign out_length     = length_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("fill count above capacity");
  a_count_stable_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.exec |=> $stable(count_r))
    else $error("fill count moved without an action");
  a_no_grow_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && sts.full |=> count_r <= $past(count_r))
    else $error("full list grew");
`endif

endmodule

FILE: src/indexed_list_store_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_store_top: fixed-capacity ordered list of words
// Append, insert, remove, read and overwrite by index, one result per
// request.
// ----------------------------------------------------------------------------
//  channel   ports                                      handshake
//  request   in_op, in_position, in_item_value          start && !busy
//  result    out_read_value, out_status, out_length     out_valid strobe
//
//  A request is captured, then decoded against the fill count in the
//  execute cycle while the cell row shifts; the result then strobes for
//  one cycle, during which the next request may already be accepted.
//  busy is high only in the execute cycle; the cell row shifts all cells in
//  parallel, so the cycle count does not depend on position or fill.
//  Reset empties the list at once; no clearing pass is needed.
//  The receiver cannot stall; each result is taken in its strobe cycle.
// ----------------------------------------------------------------------------
module indexed_list_store_top #(
  parameter int CAPACITY   = ils_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = ils_pkg::DATA_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [ils_pkg::OP_W-1:0]  in_op,
  input  logic [ils_pkg::POS_W-1:0] in_position,
  input  logic [ils_pkg::VAL_W-1:0] in_item_value,
  output logic                      out_valid,
  output logic [ils_pkg::VAL_W-1:0] out_read_value,
  output logic [ils_pkg::ST_W-1:0]  out_status,
  output logic [ils_pkg::LEN_W-1:0] out_length
);
  import ils_pkg::*;

  ils_cmd_t cmd;
  ils_sts_t sts;

  // Sequence requests
  ils_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_op     (in_op),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // Store and shift the words
  ils_dpath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_position    (in_position),
    .in_item_value  (in_item_value),
    .cmd            (cmd),
    .sts            (sts),
    .out_read_value (out_read_value),
    .out_status     (out_status),
    .out_length     (out_length)
  );

endmodule
